/* rtl/partitioned_bloom_filter_top_macros.svh */
// Assertion macros for the partitioned Bloom filter.
// Included by the modules that carry concurrent assertions.
`ifndef PARTITIONED_BLOOM_FILTER_TOP_MACROS_SVH
`define PARTITIONED_BLOOM_FILTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBF_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pbf_pkg.sv */
// Shared types and constants for the partitioned Bloom filter.
// No dependencies; every other file except the assertion macros imports this package.
`timescale 1ns / 1ps

package pbf_pkg;

    // Fixed field widths.
    localparam int MAX_HASHES      = 8;
    localparam int DEF_MAX_BUCKETS = 1024;
    localparam int HASH_WIDTH      = 32;
    localparam int HC_W            = 4;
    localparam int BKT_W           = 11;
    localparam int COUNT_W         = 14;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 11;

    // Remainder unit: bits of the hash consumed per cycle.
    localparam int STEP_BITS = 4;
    localparam int DIV_STEPS = HASH_WIDTH / STEP_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKETS    = 1'b1;

    typedef logic [1:0] op_t;

    // One classified transaction on its way from the front to the back.
    typedef struct packed {
        op_t                                op;
        logic [MAX_HASHES-1:0]              mask;
        logic [MAX_HASHES-1:0][BKT_W-1:0]   bucket;
    } pbf_entry_t;

endpackage

/* rtl/pbf_item_if.sv */
// Channel interfaces for input items and results.
// Depends on pbf_pkg.
`timescale 1ns / 1ps

interface pbf_item_if
    import pbf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    op_t                   op;
    logic [HASH_WIDTH-1:0] hash_0;
    logic [HASH_WIDTH-1:0] hash_1;
    logic [HASH_WIDTH-1:0] hash_2;
    logic [HASH_WIDTH-1:0] hash_3;
    logic [HASH_WIDTH-1:0] hash_4;
    logic [HASH_WIDTH-1:0] hash_5;
    logic [HASH_WIDTH-1:0] hash_6;
    logic [HASH_WIDTH-1:0] hash_7;

    modport source (output valid, op, hash_0, hash_1, hash_2, hash_3,
                    hash_4, hash_5, hash_6, hash_7, input ready);
    modport sink (input valid, op, hash_0, hash_1, hash_2, hash_3,
                  hash_4, hash_5, hash_6, hash_7, output ready);
endinterface

interface pbf_result_if
    import pbf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               maybe_present;
    logic [COUNT_W-1:0] set_total;

    modport source (output valid, maybe_present, set_total, input ready);
    modport sink (input valid, maybe_present, set_total, output ready);
endinterface

/* rtl/pbf_front.sv */
// Front end: accepts transactions and reduces each insert and query hash modulo the bucket count.
// Depends on pbf_pkg and pbf_item_if.
`timescale 1ns / 1ps

module pbf_front
    import pbf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    pbf_item_if.sink               item,
    input  logic                   enable,
    input  logic [BKT_W-1:0]       used_buckets,
    input  logic [MAX_HASHES-1:0]  used_mask,
    output logic                   push_valid,
    input  logic                   push_ready,
    output pbf_entry_t             push_entry
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                         state_reg, state_next;
    logic [DIV_CNT_W-1:0]               step_reg, step_next;
    op_t                                op_reg, op_next;
    logic [MAX_HASHES-1:0]              mask_reg, mask_next;
    logic [MAX_HASHES-1:0][HASH_WIDTH-1:0] hash_reg, hash_next;
    logic [MAX_HASHES-1:0][BKT_W-1:0]   rem_reg, rem_next;
    logic [MAX_HASHES-1:0][HASH_WIDTH-1:0] hash_in;
    logic [MAX_HASHES-1:0][BKT_W-1:0]   rem_step;
    logic                               accept;

    assign hash_in[0] = item.hash_0;
    assign hash_in[1] = item.hash_1;
    assign hash_in[2] = item.hash_2;
    assign hash_in[3] = item.hash_3;
    assign hash_in[4] = item.hash_4;
    assign hash_in[5] = item.hash_5;
    assign hash_in[6] = item.hash_6;
    assign hash_in[7] = item.hash_7;

    assign item.ready = (state_reg == F_IDLE) && enable;
    assign accept     = item.valid && item.ready;

    // Restoring remainder, STEP_BITS hash bits per lane each cycle.
    always_comb
    begin
        logic [BKT_W:0] r;
        for (int l = 0; l < MAX_HASHES; l++)
        begin
            r = {1'b0, rem_reg[l]};
            for (int j = 0; j < STEP_BITS; j++)
            begin
                r = {r[BKT_W-1:0], hash_reg[l][HASH_WIDTH-1-j]};
                if (r >= {1'b0, used_buckets})
                begin
                    r = r - {1'b0, used_buckets};
                end
            end
            rem_step[l] = r[BKT_W-1:0];
        end
    end

    // Sequencer: accept, iterate the remainder, hand off to the queue.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        op_next    = op_reg;
        mask_next  = mask_reg;
        hash_next  = hash_reg;
        rem_next   = rem_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    op_next   = item.op;
                    mask_next = used_mask;
                    hash_next = hash_in;
                    rem_next  = '0;
                    step_next = '0;
                    if (item.op == OP_INSERT || item.op == OP_QUERY)
                    begin
                        state_next = F_DIV;
                    end
                    else
                    begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_DIV:
            begin
                rem_next = rem_step;
                for (int l = 0; l < MAX_HASHES; l++)
                begin
                    hash_next[l] = hash_reg[l] << STEP_BITS;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        mask_reg <= mask_next;
        hash_reg <= hash_next;
        rem_reg  <= rem_next;
    end

    assign push_valid        = (state_reg == F_PUSH);
    assign push_entry.op     = op_reg;
    assign push_entry.mask   = mask_reg;
    assign push_entry.bucket = rem_reg;

endmodule

/* rtl/pbf_queue.sv */
// Two-entry queue between the front end and the bit store engine.
// Depends on pbf_pkg.
`timescale 1ns / 1ps

module pbf_queue
    import pbf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  pbf_entry_t push_entry,
    output logic       pop_valid,
    input  logic       pop_ready,
    output pbf_entry_t pop_entry
);

    pbf_entry_t  entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic        do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_entry  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/pbf_back.sv */
// Back end: bit store rows, read-modify-write, clearing sweeps and result register.
// Depends on pbf_pkg, pbf_item_if and the assertion macros.
`timescale 1ns / 1ps
`include "partitioned_bloom_filter_top_macros.svh"

module pbf_back
    import pbf_pkg::*;
#(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  pbf_entry_t  pop_entry,
    pbf_result_if.source result,
    output logic        init_busy
);

    localparam int AW = $clog2(MAX_BUCKETS);
    localparam logic [AW-1:0] PTR_LAST = AW'(MAX_BUCKETS - 1);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]               state_reg;
    logic [AW-1:0]            ptr_reg;
    logic [COUNT_W-1:0]       count_reg;
    pbf_entry_t               cur_reg;
    logic                     present_reg;
    logic                     res_valid_reg;
    logic                     res_present_reg;
    logic [COUNT_W-1:0]       res_bits_reg;
    logic                     sweeping;
    logic                     pop_fire;
    logic [MAX_HASHES-1:0]    rd_bits;
    logic [MAX_HASHES-1:0]    wr_en;
    logic [MAX_HASHES-1:0]    new_bits;
    logic [MAX_HASHES-1:0][AW-1:0] wr_addr;

    assign sweeping  = (state_reg == S_SWEEP) || (state_reg == S_INIT);
    assign pop_ready = (state_reg == S_IDLE);
    assign pop_fire  = pop_valid && pop_ready;
    assign init_busy = (state_reg == S_INIT);

    // Write control: sweeps clear every row, inserts set bits not yet set.
    always_comb
    begin
        for (int g = 0; g < MAX_HASHES; g++)
        begin
            wr_en[g] = sweeping || (state_reg == S_UPDATE && cur_reg.op == OP_INSERT &&
                                    cur_reg.mask[g] && !rd_bits[g]);
            wr_addr[g] = sweeping ? ptr_reg : AW'(cur_reg.bucket[g]);
        end
        new_bits = sweeping ? '0 : wr_en;
    end

    // One single-bit memory per row; reads happen when an entry is popped.
    for (genvar g = 0; g < MAX_HASHES; g++)
    begin : g_row
        logic mem [MAX_BUCKETS];
        logic rd_bit_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en[g])
            begin
                mem[wr_addr[g]] <= !sweeping;
            end
            if (pop_fire)
            begin
                rd_bit_reg <= mem[AW'(pop_entry.bucket[g])];
            end
        end

        assign rd_bits[g] = rd_bit_reg;
    end

    // Engine sequencer and output data register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            ptr_reg         <= '0;
            count_reg       <= '0;
            cur_reg         <= '0;
            present_reg     <= 1'b0;
            res_present_reg <= 1'b0;
            res_bits_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_INIT:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == PTR_LAST)
                    begin
                        ptr_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        cur_reg     <= pop_entry;
                        present_reg <= 1'b0;
                        case (pop_entry.op)
                            OP_INSERT, OP_QUERY: state_reg <= S_UPDATE;
                            OP_CLEAR:            state_reg <= S_SWEEP;
                            default:             state_reg <= S_OUT;
                        endcase
                    end
                end
                S_UPDATE:
                begin
                    count_reg   <= count_reg + COUNT_W'($countones(new_bits));
                    present_reg <= (cur_reg.op == OP_QUERY) && (&(rd_bits | ~cur_reg.mask));
                    state_reg   <= S_OUT;
                end
                S_SWEEP:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == PTR_LAST)
                    begin
                        ptr_reg   <= '0;
                        count_reg <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!res_valid_reg || result.ready)
                    begin
                        res_present_reg <= present_reg;
                        res_bits_reg    <= count_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result valid: set whenever a result is loaded, cleared once it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= (state_reg == S_OUT) || (res_valid_reg && !result.ready);
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.maybe_present = res_present_reg;
    assign result.set_total     = res_bits_reg;

    // A clear sweep ends with an empty count and a result pending.
    `PBF_ASSERT_NEXT(a_clear_zero, clk, rst_n, state_reg == S_SWEEP && ptr_reg == PTR_LAST, count_reg == '0 && state_reg == S_OUT, "clear sweep did not zero the count")
    // Queries and reserved ops never change the count.
    `PBF_ASSERT_NEXT(a_query_count, clk, rst_n, state_reg == S_UPDATE && cur_reg.op != OP_INSERT, count_reg == $past(count_reg), "count changed without an insert")
    // No row is written while the engine waits for work.
    `PBF_ASSERT_NOW(a_idle_no_write, clk, rst_n, state_reg == S_IDLE, wr_en == '0, "bit store written while idle")

endmodule

/* rtl/partitioned_bloom_filter_top.sv */
// Top level of the partitioned Bloom filter: configuration registers and wiring.
// Depends on pbf_pkg, the channel interfaces, pbf_front, pbf_queue and pbf_back.
`timescale 1ns / 1ps

// In the front end, insert and query transactions have all eight 32-bit hashes
// reduced in parallel, four bits a cycle; that remainder unit sets the sustained
// rate. The back end's read-modify-write overlaps with the next reduction
// through a two-entry queue. A clear sweeps every row at once, one bucket a
// cycle. After reset the same sweep runs over all MAX_BUCKETS buckets, during
// which no transaction is accepted; configuration writes are taken at any time.
module partitioned_bloom_filter_top
    import pbf_pkg::*;
#(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    pbf_item_if.sink              item,
    pbf_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [HC_W-1:0]        hash_count_reg;
    logic [BKT_W-1:0]       buckets_reg;
    logic [BKT_W-1:0]       used_buckets;
    logic [HC_W-1:0]        used_hashes;
    logic [MAX_HASHES-1:0]  used_mask;
    logic                   init_busy;
    logic                   push_valid, push_ready;
    logic                   pop_valid, pop_ready;
    pbf_entry_t             push_entry, pop_entry;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_count_reg <= HC_W'(8);
            buckets_reg    <= BKT_W'(1024);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HASH_COUNT: hash_count_reg <= cfg_data[HC_W-1:0];
                CFG_BUCKETS:    buckets_reg    <= cfg_data[BKT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Clamp the configured values into their usable ranges.
    always_comb
    begin
        if (hash_count_reg == '0)
        begin
            used_hashes = HC_W'(1);
        end
        else if (hash_count_reg > HC_W'(MAX_HASHES))
        begin
            used_hashes = HC_W'(MAX_HASHES);
        end
        else
        begin
            used_hashes = hash_count_reg;
        end

        if (buckets_reg == '0)
        begin
            used_buckets = BKT_W'(1);
        end
        else if (32'(buckets_reg) > MAX_BUCKETS)
        begin
            used_buckets = BKT_W'(MAX_BUCKETS);
        end
        else
        begin
            used_buckets = buckets_reg;
        end

        for (int r = 0; r < MAX_HASHES; r++)
        begin
            used_mask[r] = (HC_W'(r) < used_hashes);
        end
    end

    pbf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .enable       (!init_busy),
        .used_buckets (used_buckets),
        .used_mask    (used_mask),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    pbf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    pbf_back #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .result    (result),
        .init_busy (init_busy)
    );

endmodule

/* dv/tb_partitioned_bloom_filter_top.sv */
// Self-checking testbench for the partitioned Bloom filter top level.
// It drives insert, query, clear and reserved transactions and predicts every result.
// Depends on pbf_pkg, the channel interfaces and partitioned_bloom_filter_top.
`timescale 1ns / 1ps

module tb_partitioned_bloom_filter_top;
    import pbf_pkg::*;

    localparam op_t OP_RESERVED   = 2'd3;
    localparam int  BUCKETS       = DEF_MAX_BUCKETS;
    localparam int  WATCHDOG_MAX  = 20000;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  HISTORY_DEPTH = 64;
    localparam int  PHASE_ITEMS   = 300;

    typedef logic [HASH_WIDTH-1:0] hash_vec_t [MAX_HASHES];

    typedef struct {
        logic               maybe_present;
        logic [COUNT_W-1:0] set_total;
    } filter_answer_t;

    typedef struct {
        op_t                op;
        logic [HASH_WIDTH-1:0] fill;
        bit                 typed;
        logic               maybe_present;
        logic [COUNT_W-1:0] set_total;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pbf_item_if   item_ch ();
    pbf_result_if res_ch ();

    partitioned_bloom_filter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch.sink),
        .result    (res_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the filter state and its registers.
    bit                 shadow_bits [MAX_HASHES][BUCKETS];
    int unsigned        shadow_count;
    logic [HC_W-1:0]    shadow_hash_count;
    logic [BKT_W-1:0]   shadow_buckets;

    filter_answer_t     pending_answers [$];
    hash_vec_t          insert_history [$];

    int  fail_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_request;
    int  hold_left;
    int  quiet_cycles;

    // Clock generation.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Applies one accepted transaction to the shadow store and returns its answer.
    function automatic filter_answer_t apply_filter_op(op_t op, hash_vec_t h);
        filter_answer_t ans;
        int unsigned rows;
        int unsigned mod;
        int unsigned b;
        ans.maybe_present = 1'b0;
        rows = (shadow_hash_count == 0) ? 1 :
               (shadow_hash_count > MAX_HASHES) ? MAX_HASHES : shadow_hash_count;
        mod = (shadow_buckets == 0) ? 1 :
              (shadow_buckets > BUCKETS) ? BUCKETS : shadow_buckets;
        if (op == OP_INSERT)
        begin
            for (int r = 0; r < rows; r++)
            begin
                b = h[r] % mod;
                if (!shadow_bits[r][b])
                begin
                    shadow_bits[r][b] = 1'b1;
                    shadow_count++;
                end
            end
        end
        else if (op == OP_QUERY)
        begin
            ans.maybe_present = 1'b1;
            for (int r = 0; r < rows; r++)
            begin
                b = h[r] % mod;
                if (!shadow_bits[r][b])
                    ans.maybe_present = 1'b0;
            end
        end
        else if (op == OP_CLEAR)
        begin
            for (int r = 0; r < MAX_HASHES; r++)
                for (int c = 0; c < BUCKETS; c++)
                    shadow_bits[r][c] = 1'b0;
            shadow_count = 0;
        end
        ans.set_total = shadow_count[COUNT_W-1:0];
        return ans;
    endfunction

    // Offers one transaction, waits for acceptance and records what it should return.
    task automatic send_item(op_t op, hash_vec_t h, bit typed, filter_answer_t typed_ans);
        int gap;
        filter_answer_t ans;
        @(negedge clk);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 12);
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.op     <= op;
        item_ch.hash_0 <= h[0];
        item_ch.hash_1 <= h[1];
        item_ch.hash_2 <= h[2];
        item_ch.hash_3 <= h[3];
        item_ch.hash_4 <= h[4];
        item_ch.hash_5 <= h[5];
        item_ch.hash_6 <= h[6];
        item_ch.hash_7 <= h[7];
        do
            @(posedge clk);
        while (!item_ch.ready);
        ans = apply_filter_op(op, h);
        pending_answers.push_back(typed ? typed_ans : ans);
        if (op == OP_INSERT)
        begin
            insert_history.push_back(h);
            if (insert_history.size() > HISTORY_DEPTH)
                void'(insert_history.pop_front());
        end
    endtask

    // Lowers valid and waits until every outstanding result has come back.
    task automatic drain_results();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    // Writes both registers while the filter is idle.
    task automatic configure(logic [CFG_DATA_W-1:0] hashes, logic [CFG_DATA_W-1:0] buckets);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HASH_COUNT;
        cfg_data  <= hashes;
        @(negedge clk);
        cfg_index <= CFG_BUCKETS;
        cfg_data  <= buckets;
        @(posedge clk);
        shadow_hash_count = hashes[HC_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        shadow_buckets = buckets[BKT_W-1:0];
    endtask

    // Builds a random transaction; queries often replay an earlier insert.
    task automatic random_item(output op_t op, output hash_vec_t h);
        int pick;
        pick = $urandom_range(0, 999);
        op = (pick < 500) ? OP_INSERT : (pick < 960) ? OP_QUERY :
             (pick < 970) ? OP_CLEAR : OP_RESERVED;
        for (int r = 0; r < MAX_HASHES; r++)
            h[r] = ($urandom_range(0, 3) == 0) ? HASH_WIDTH'($urandom_range(0, 15))
                                               : HASH_WIDTH'($urandom);
        if (op == OP_QUERY && insert_history.size() > 0 && $urandom_range(0, 1))
        begin
            h = insert_history[$urandom_range(0, insert_history.size() - 1)];
            if ($urandom_range(0, 3) == 0)
                h[$urandom_range(0, MAX_HASHES - 1)] = $urandom;
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        res_ch.ready = 1'b0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        filter_answer_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result maybe_present=%0b set_total=%0d",
                         $realtime, res_ch.maybe_present, res_ch.set_total);
                fail_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (res_ch.maybe_present !== want.maybe_present)
                begin
                    $display("%0t: maybe_present expected %0b actual %0b",
                             $realtime, want.maybe_present, res_ch.maybe_present);
                    fail_count++;
                end
                if (res_ch.set_total !== want.set_total)
                begin
                    $display("%0t: set_total expected %0d actual %0d",
                             $realtime, want.set_total, res_ch.set_total);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction or taken result.
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Main sequence: directed table, then random phases over several settings.
    initial
    begin
        directed_row_t  table_rows [$];
        hash_vec_t      h;
        op_t            op;
        filter_answer_t typed_ans;
        int             mode;
        logic [CFG_DATA_W-1:0] phase_hashes  [6];
        logic [CFG_DATA_W-1:0] phase_buckets [6];

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_HASH_COUNT;
        cfg_data       = '0;
        item_ch.valid  = 1'b0;
        item_ch.op     = OP_INSERT;
        item_ch.hash_0 = '0;
        item_ch.hash_1 = '0;
        item_ch.hash_2 = '0;
        item_ch.hash_3 = '0;
        item_ch.hash_4 = '0;
        item_ch.hash_5 = '0;
        item_ch.hash_6 = '0;
        item_ch.hash_7 = '0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        quiet_cycles   = 0;
        shadow_count   = 0;
        shadow_hash_count = 4'd8;
        shadow_buckets    = 11'd1024;
        foreach (shadow_bits[r, c])
            shadow_bits[r][c] = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows under the reset settings; all-ones hashes land in bucket 1023.
        table_rows = '{
            '{OP_QUERY,    32'h0000_0000, 1'b1, 1'b0, 14'd0},
            '{OP_INSERT,   32'h0000_0000, 1'b1, 1'b0, 14'd8},
            '{OP_INSERT,   32'h0000_0000, 1'b1, 1'b0, 14'd8},
            '{OP_QUERY,    32'h0000_0000, 1'b1, 1'b1, 14'd8},
            '{OP_QUERY,    32'hFFFF_FFFF, 1'b1, 1'b0, 14'd8},
            '{OP_INSERT,   32'hFFFF_FFFF, 1'b1, 1'b0, 14'd16},
            '{OP_QUERY,    32'hFFFF_FFFF, 1'b1, 1'b1, 14'd16},
            '{OP_RESERVED, 32'hFFFF_FFFF, 1'b1, 1'b0, 14'd16},
            '{OP_INSERT,   32'hAAAA_AAAA, 1'b0, 1'b0, 14'd0},
            '{OP_QUERY,    32'hAAAA_AAAA, 1'b0, 1'b0, 14'd0},
            '{OP_INSERT,   32'h5555_5555, 1'b0, 1'b0, 14'd0},
            '{OP_QUERY,    32'h8000_0400, 1'b0, 1'b0, 14'd0},
            '{OP_CLEAR,    32'h0000_0000, 1'b1, 1'b0, 14'd0},
            '{OP_QUERY,    32'hFFFF_FFFF, 1'b1, 1'b0, 14'd0}
        };
        foreach (table_rows[i])
        begin
            for (int r = 0; r < MAX_HASHES; r++)
                h[r] = table_rows[i].fill;
            typed_ans.maybe_present = table_rows[i].maybe_present;
            typed_ans.set_total     = table_rows[i].set_total;
            send_item(table_rows[i].op, h, table_rows[i].typed, typed_ans);
        end
        drain_results();

        // Settings include zero and over-range values, which the filter clamps.
        phase_hashes  = '{11'd8, 11'd1, 11'd0,    11'd15, 11'd3, 11'd8};
        phase_buckets = '{11'd1024, 11'd1, 11'd2047, 11'd0, 11'd7, 11'd1024};

        for (int p = 0; p < 6; p++)
        begin
            configure(phase_hashes[p], phase_buckets[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Change the idling pattern every 60 transactions.
                if (n % 60 == 0)
                begin
                    mode = (n / 60 + p) % 4;
                    send_idle_pct  = (mode == 1) ? 86 : (mode == 3) ? 38 : 0;
                    recv_stall_pct = (mode == 2) ? 86 : (mode == 3) ? 38 : 0;
                end
                // Once, hold results back long enough for the input to stall.
                if (p == 0 && n == 30)
                    hold_request = 1'b1;
                random_item(op, h);
                send_item(op, h, 1'b0, typed_ans);
            end
            drain_results();
        end

        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending_answers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/pbf_pkg.sv
rtl/pbf_item_if.sv
rtl/pbf_front.sv
rtl/pbf_queue.sv
rtl/pbf_back.sv
rtl/partitioned_bloom_filter_top.sv
dv/tb_partitioned_bloom_filter_top.sv
